FILE: hdl/lhpf_pkg.sv
// lhpf_pkg: constants, log2 table and saturation helper for the log halo force core.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps
`default_nettype none
package lhpf_pkg;

  localparam int LOG_TABLE_BITS = 8;
  localparam int TBL_SIZE       = 1 << LOG_TABLE_BITS;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam int DIV_STEPS = 32;             // quotient bits below the overflow limit
  localparam int LANE_LAT  = DIV_STEPS + 2;  // setup stage + steps + round/clamp
  localparam int LOG_LAT   = 4;
  localparam int FRONT_LAT = 3;
  localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_RSQ  = 1'd1;

  typedef logic [15:0] rom_word_t;
  typedef rom_word_t [TBL_SIZE-1:0] rom_t;

  // log2(1 + i/2^N) in Q0.16, by repeated squaring of a Q1.31 mantissa
  function automatic rom_t build_rom();
    rom_t rom;
    logic [63:0] m;
    logic [63:0] f;
    logic [63:0] fr;
    for (int i = 0; i < TBL_SIZE; i++) begin
      m = (64'd1 << 31) + (64'(i) << (31 - LOG_TABLE_BITS));
      f = '0;
      for (int k = 1; k <= 24; k++) begin
        m = (m * m) >> 31;
        if (m >= (64'd1 << 32)) begin
          m = m >> 1;
          f = f | (64'd1 << (24 - k));
        end
      end
      fr = (f + 64'd128) >> 8;
      rom[i] = fr[15:0];
    end
    return rom;
  endfunction

  localparam rom_t LOG_ROM = build_rom();

  // returns {sat, value}: sign/magnitude clamped to signed 32 bits
  function automatic logic [32:0] clamp_s32(input logic neg, input logic [63:0] mag);
    logic [31:0] v;
    logic s;
    s = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        v = 32'h8000_0000;
        s = 1'b1;
      end else begin
        v = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        v = 32'h7FFF_FFFF;
        s = 1'b1;
      end else begin
        v = mag[31:0];
      end
    end
    return {s, v};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lhpf_log.sv
// lhpf_log: potential path, leading-one search, table log2, ln2 and scale multiplies.
// Output is delayed to line up with the division lanes. Depends on lhpf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lhpf_log (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad,
  input  wire logic [31:0] log_scale,
  output logic [31:0]      pot,
  output logic             sat
);
  import lhpf_pkg::*;

  localparam int DLY = LANE_LAT - LOG_LAT;

  logic [5:0]                p_nxt, p_r;
  logic [LOG_TABLE_BITS-1:0] idx_nxt, idx_r;
  logic [63+LOG_TABLE_BITS:0] shf;
  logic [21:0] l2_nxt, l2_r;
  logic        lneg_r, lneg2_r;
  logic [53:0] lnprod;
  logic [21:0] ln_nxt, ln_r;
  logic [53:0] pprod;
  logic [63:0] pmag;
  logic [32:0] clamp;
  logic [31:0] pot_r [DLY+1];
  logic        sat_r [DLY+1];

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 64; i++) begin
      if (rad[i]) p_nxt = 6'(i);
    end
    shf = {rad, {LOG_TABLE_BITS{1'b0}}} >> p_nxt;
    idx_nxt = shf[LOG_TABLE_BITS-1:0];
  end

  always_comb begin
    if (p_r[5]) begin
      l2_nxt = {1'b0, p_r[4:0], LOG_ROM[idx_r]};
    end else begin
      l2_nxt = {6'd32 - p_r, 16'd0} - {6'd0, LOG_ROM[idx_r]};
    end
    lnprod = 54'(l2_r) * 54'(LN2_Q32) + 54'h8000_0000;
    ln_nxt = lnprod[53:32];
    pprod  = 54'(ln_r) * 54'(log_scale) + 54'h8000;
    pmag   = {26'd0, pprod[53:16]};
    // sign travels alongside ln_r
    clamp  = clamp_s32(lneg2_r && (pmag != 64'd0), pmag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      idx_r   <= idx_nxt;
      l2_r    <= l2_nxt;
      lneg_r  <= ~p_r[5];
      ln_r    <= ln_nxt;
      lneg2_r <= lneg_r;
      pot_r[0] <= clamp[31:0];
      sat_r[0] <= clamp[32];
      for (int k = 1; k <= DLY; k++) begin
        pot_r[k] <= pot_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign pot = pot_r[DLY];
  assign sat = sat_r[DLY];

endmodule
`default_nettype wire

FILE: hdl/lhpf_div_lane.sv
// lhpf_div_lane: one acceleration lane, pipelined restoring division of num*2^16 by rad,
// one quotient bit per stage, then rounding and clamping. Depends on lhpf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lhpf_div_lane (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [63:0] rad,
  input  wire logic        neg,
  output logic [31:0]      accel,
  output logic             sat
);
  import lhpf_pkg::*;

  logic [63:0]          rem_r [DIV_STEPS+1];
  logic [31:0]          dlo_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_r   [DIV_STEPS+1];
  logic [63:0]          d_r   [DIV_STEPS+1];
  logic                 big_r [DIV_STEPS+1];
  logic                 neg_r [DIV_STEPS+1];

  logic [63:0]          rem_nxt [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_nxt   [DIV_STEPS];
  logic [64:0]          trial   [DIV_STEPS];
  logic [64:0]          diff    [DIV_STEPS];

  logic [64:0] qrnd;
  logic [63:0] qmag;
  logic [63:0] rest;
  logic [32:0] clamp;
  logic [31:0] acc_r;
  logic        sat_r;

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem_r[k], dlo_r[k][31]};
      diff[k]  = trial[k] - {1'b0, d_r[k]};
      if (trial[k] >= {1'b0, d_r[k]}) begin
        rem_nxt[k] = diff[k][63:0];
        q_nxt[k]   = {q_r[k][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][63:0];
        q_nxt[k]   = {q_r[k][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rest = d_r[DIV_STEPS] - rem_r[DIV_STEPS];
    qrnd = {33'd0, q_r[DIV_STEPS]} + ((rem_r[DIV_STEPS] >= rest) ? 65'd1 : 65'd0);
    // quotient at or above 2^32 always clamps
    qmag  = big_r[DIV_STEPS] ? 64'h2_0000_0000 : qrnd[63:0];
    clamp = clamp_s32(~neg_r[DIV_STEPS] && (qmag != 64'd0), qmag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {16'd0, num[63:16]};
      dlo_r[0] <= {num[15:0], 16'd0};
      q_r[0]   <= '0;
      d_r[0]   <= rad;
      big_r[0] <= ({16'd0, num} >= {rad, 16'd0});
      neg_r[0] <= neg;
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        dlo_r[k+1] <= {dlo_r[k][30:0], 1'b0};
        q_r[k+1]   <= q_nxt[k];
        d_r[k+1]   <= d_r[k];
        big_r[k+1] <= big_r[k];
        neg_r[k+1] <= neg_r[k];
      end
      acc_r <= clamp[31:0];
      sat_r <= clamp[32];
    end
  end

  assign accel = acc_r;
  assign sat   = sat_r;

endmodule
`default_nettype wire

FILE: hdl/log_halo_potential_force_core.sv
// log_halo_potential_force_core: top level, config registers, squares, radius sum,
// three division lanes plus the potential path, merged into one result word.
// Depends on lhpf_pkg, lhpf_log, lhpf_div_lane.
//
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_pos_x/y/z        | position word in
//  out     | out_valid, out_stall, out_potential,    | result word out
//          | out_accel_x/y/z, out_saturated          |
//  cfg     | cfg_we, cfg_index, cfg_data             | register write
//
// One word per cycle while the output is not stalled; 3 front stages and 34 lane stages
// (set by the 32-step division pipeline). The whole pipeline holds when the output word
// is stalled. Reset clears the valid chain and reloads the registers.
`timescale 1ns / 1ps
`default_nettype none
module log_halo_potential_force_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [31:0]              in_pos_x,
  input  wire logic signed [31:0]              in_pos_y,
  input  wire logic signed [31:0]              in_pos_z,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [31:0]                   out_potential,
  output logic signed [31:0]                   out_accel_x,
  output logic signed [31:0]                   out_accel_y,
  output logic signed [31:0]                   out_accel_z,
  output logic                                 out_saturated,
  input  wire logic                            cfg_we,
  input  wire logic [lhpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  import lhpf_pkg::*;

  logic [31:0] log_scale_r, core_rsq_r;
  logic        en;
  logic        vld_r [PIPE_LAT];
  logic [31:0] pos [3];
  logic [31:0] mag_r [3];
  logic        neg1_r [3], neg2_r [3], neg3_r [3];
  logic [63:0] sq_r [3];
  logic [63:0] num2_r [3], num3_r [3];
  logic [63:0] rad_sum, rad_r;
  logic [31:0] acc [3];
  logic        lsat [3];
  logic [31:0] pot;
  logic        psat;

  assign en       = ~(vld_r[PIPE_LAT-1] & out_stall);
  assign in_stall = ~en;
  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_scale_r <= 32'd32768;
      core_rsq_r  <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOG_SCALE: log_scale_r <= cfg_data;
        REG_CORE_RSQ:  core_rsq_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < PIPE_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_comb begin
    rad_sum = {16'd0, core_rsq_r, 16'd0} + sq_r[0] + sq_r[1] + sq_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        neg1_r[j] <= pos[j][31];
        mag_r[j]  <= pos[j][31] ? 32'd0 - pos[j] : pos[j];
        sq_r[j]   <= 64'(mag_r[j]) * 64'(mag_r[j]);
        num2_r[j] <= {63'(log_scale_r) * 63'(mag_r[j]), 1'b0};
        neg2_r[j] <= neg1_r[j];
        num3_r[j] <= num2_r[j];
        neg3_r[j] <= neg2_r[j];
      end
      rad_r <= (rad_sum == 64'd0) ? 64'd1 : rad_sum;
    end
  end

  lhpf_log u_log (
    .clk       (clk),
    .en        (en),
    .rad       (rad_r),
    .log_scale (log_scale_r),
    .pot       (pot),
    .sat       (psat)
  );

  for (genvar j = 0; j < 3; j++) begin : g_lane
    lhpf_div_lane u_lane (
      .clk   (clk),
      .en    (en),
      .num   (num3_r[j]),
      .rad   (rad_r),
      .neg   (neg3_r[j]),
      .accel (acc[j]),
      .sat   (lsat[j])
    );
  end

  assign out_valid     = vld_r[PIPE_LAT-1];
  assign out_potential = pot;
  assign out_accel_x   = acc[0];
  assign out_accel_y   = acc[1];
  assign out_accel_z   = acc[2];
  assign out_saturated = psat | lsat[0] | lsat[1] | lsat[2];

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for log_halo_potential_force_core.
// Predicts potential, accelerations and the clamp flag per position word; uses lhpf_pkg.
`timescale 1ns / 1ps
module tb_top;
  import lhpf_pkg::*;

  localparam int DRAIN_CYCLES = PIPE_LAT + 20;

  typedef struct packed {
    logic signed [31:0] potential;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic               saturated;
  } force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_potential, out_accel_x, out_accel_y, out_accel_z;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  log_halo_potential_force_core DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[log_halo_potential_force_core] ERROR");
    $finish;
  end

  // predictor state
  logic [31:0] scale_q16 = 32'd32768;
  logic [31:0] core_rsq_q16 = 32'd65536;
  logic [15:0] log2_tbl [TBL_SIZE];
  force_t expected_forces[$];
  int fail_cnt = 0;
  bit stall_busy = 1'b0;

  initial begin
    logic [63:0] m, f;
    for (int i = 0; i < TBL_SIZE; i++) begin
      m = (64'd1 << 31) + (64'(i) << (31 - LOG_TABLE_BITS));
      f = '0;
      for (int k = 1; k <= 24; k++) begin
        m = (m * m) >> 31;
        if (m >= (64'd1 << 32)) begin
          m = m >> 1;
          f[24-k] = 1'b1;
        end
      end
      log2_tbl[i] = 16'((f + 64'd128) >> 8);
    end
  end

  function automatic logic [31:0] sat_s32(input bit neg, input logic [63:0] mag,
                                          inout bit sat);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  function automatic force_t halo_force(input logic signed [31:0] px, py, pz);
    force_t res;
    logic signed [31:0] pos [3];
    logic [31:0] mag [3];
    bit neg [3];
    bit sat, lneg;
    logic [63:0] r, l2mag, lnmag, pmag, q;
    logic [127:0] num;
    logic [191:0] qw;
    logic [127:0] rem;
    longint l2;
    int p;
    int unsigned idx;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    sat = 1'b0;
    r = 64'(core_rsq_q16) << 16;
    for (int j = 0; j < 3; j++) begin
      neg[j] = pos[j][31];
      mag[j] = neg[j] ? 32'd0 - pos[j] : pos[j];
      r += 64'(mag[j]) * 64'(mag[j]);
    end
    if (r == 0) r = 64'd1;
    p = 63;
    while (!r[p]) p--;
    if (p >= LOG_TABLE_BITS) idx = 32'((r >> (p - LOG_TABLE_BITS)) & (TBL_SIZE - 1));
    else idx = 32'((r << (LOG_TABLE_BITS - p)) & (TBL_SIZE - 1));
    l2 = longint'(p - 32) * 65536 + longint'(log2_tbl[idx]);
    lneg = l2 < 0;
    l2mag = lneg ? 64'(-l2) : 64'(l2);
    lnmag = (l2mag * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
    pmag = (lnmag * 64'(scale_q16) + 64'h8000) >> 16;
    res.potential = sat_s32(lneg && pmag != 0, pmag, sat);
    for (int j = 0; j < 3; j++) begin
      num = (128'd2 * 128'(scale_q16) * 128'(mag[j])) << 16;
      qw = 192'(num) / 192'(r);
      rem = num - 128'(qw) * 128'(r);
      if (qw >= (192'd1 << 33)) q = 64'd1 << 33;
      else begin
        q = 64'(qw);
        if (rem >= 128'(r) - rem) q++;
      end
      if (j == 0) res.accel_x = sat_s32(!neg[j] && q != 0, q, sat);
      if (j == 1) res.accel_y = sat_s32(!neg[j] && q != 0, q, sat);
      if (j == 2) res.accel_z = sat_s32(!neg[j] && q != 0, q, sat);
    end
    res.saturated = sat;
    return res;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!stall_busy) out_stall <= 1'b0;
    else if (r < 30) out_stall <= 1'b1;
    else if (r < 70) out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    force_t exp_f;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_forces.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
      end else begin
        exp_f = expected_forces.pop_front();
        if (out_potential !== exp_f.potential) begin
          $error("potential exp %h got %h", exp_f.potential, out_potential);
          fail_cnt++;
        end
        if (out_accel_x !== exp_f.accel_x) begin
          $error("accel_x exp %h got %h", exp_f.accel_x, out_accel_x);
          fail_cnt++;
        end
        if (out_accel_y !== exp_f.accel_y) begin
          $error("accel_y exp %h got %h", exp_f.accel_y, out_accel_y);
          fail_cnt++;
        end
        if (out_accel_z !== exp_f.accel_z) begin
          $error("accel_z exp %h got %h", exp_f.accel_z, out_accel_z);
          fail_cnt++;
        end
        if (out_saturated !== exp_f.saturated) begin
          $error("saturated exp %b got %b", exp_f.saturated, out_saturated);
          fail_cnt++;
        end
      end
    end
  end

  int burst_left = 0;

  task automatic send_pos(input logic [31:0] x, y, z, input bit gaps);
    int gap;
    if (gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    do @(posedge clk); while (in_stall);
    expected_forces.push_back(halo_force(x, y, z));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_forces.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_LOG_SCALE) scale_q16 = val;
    else if (idx == REG_CORE_RSQ) core_rsq_q16 = val;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000);
      2: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edges [6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h0001_0000};
    for (int i = 0; i < 6; i++)
      send_pos(edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6], 1'b0);
    send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_pos(32'hFFFF_0000, 32'h0, 32'h0, 1'b0);
    idle_input();
    drain();
    // zero core radius: origin forces the smallest radius
    write_reg(REG_CORE_RSQ, 32'd0);
    write_reg(REG_LOG_SCALE, 32'hFFFF_FFFF);
    send_pos(32'h0, 32'h0, 32'h0, 1'b0);
    send_pos(32'h1, 32'h0, 32'h0, 1'b0);
    send_pos(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_pos(32'h0, 32'h0, 32'h0000_0100, 1'b0);
    idle_input();
    drain();
    write_reg(REG_LOG_SCALE, 32'd0);
    send_pos(32'h0, 32'h0, 32'h0, 1'b0);
    send_pos(32'h1234_5678, 32'h8765_4321, 32'h0, 1'b0);
    idle_input();
    drain();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_pos(rand_coord(), rand_coord(), rand_coord(), 1'b1);
    idle_input();
    drain();
  endtask

  task automatic test_settings();
    logic [31:0] scales [5] = '{32'd32768, 32'hFFFF_FFFF, 32'd1, 32'h0010_0000, 32'd0};
    logic [31:0] rsqs [5] = '{32'd65536, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'h0000_4000};
    for (int s = 0; s < 5; s++) begin
      write_reg(REG_LOG_SCALE, scales[s]);
      write_reg(REG_CORE_RSQ, rsqs[s]);
      test_random(200);
    end
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_LOG_SCALE, $urandom);
      write_reg(REG_CORE_RSQ, $urandom);
      test_random(225);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_busy = 1'b1;
    test_settings();
    stall_busy = 1'b0;
    if (fail_cnt == 0 && expected_forces.size() == 0)
      $display("[log_halo_potential_force_core] OK");
    else
      $display("[log_halo_potential_force_core] ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/lhpf_pkg.sv
hdl/lhpf_log.sv
hdl/lhpf_div_lane.sv
hdl/log_halo_potential_force_core.sv
tb/sv/tb_top.sv
